@@ hdl/ntwk_pkg.sv @@
// Shared constants, types and the scale key table for the number-to-word-keys block.
`default_nettype none
package ntwk_pkg;

   localparam int VALUE_W        = 64;
   localparam int KEY_W          = 60;
   localparam int MAX_GROUPS     = 7;
   localparam int NUM_GROUPS     = 7;
   localparam int GRP_W          = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int DIGITS_PER_GRP = 3;
   localparam int NDIG           = NUM_GROUPS * DIGITS_PER_GRP;
   localparam int BCD_W          = NDIG * 4;
   localparam int GRP_BITS       = DIGITS_PER_GRP * 4;
   localparam int BITS_PER_STEP  = 4;
   localparam int CONV_STEPS     = VALUE_W / BITS_PER_STEP;
   localparam int CNT_W          = $clog2(CONV_STEPS);

   localparam logic [KEY_W-1:0] SCALE_KEY [MAX_GROUPS] = '{
      60'd0,
      60'd1000,
      60'd1000000,
      60'd1000000000,
      60'd1000000000000,
      60'd1000000000000000,
      60'd1000000000000000000
   };

   typedef struct packed {
      logic load;
      logic step;
      logic first;
      logic emit;
   } ntwk_cmd_type;

   typedef struct packed {
      logic out_free;
      logic key_last;
   } ntwk_stat_type;

endpackage
`default_nettype wire

@@ hdl/ntwk_ctrl.sv @@
// Sequencer: accept, binary-to-decimal conversion steps, group setup, key emission.
`default_nettype none
module ntwk_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire ntwk_pkg::ntwk_stat_type stat,
   output      ntwk_pkg::ntwk_cmd_type  cmd
);
   import ntwk_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_CONV  = 4'b0010,
      S_FIRST = 4'b0100,
      S_EMIT  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CONV_STEPS - 1)) state_in = S_FIRST;
         end
         S_FIRST: begin
            cmd.first = 1'b1;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.key_last) state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_conv_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CONV && cnt_ff == CNT_W'(CONV_STEPS - 1)) |=> state_ff == S_FIRST)
      else $error("conversion did not end after its step count");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("key issued while output register busy");
   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_ready)
      else $error("ready while an item is in work");
`endif

endmodule
`default_nettype wire

@@ hdl/ntwk_dp.sv @@
// Datapath: double-dabble decimal conversion, group walk, key select, output register.
`default_nettype none
module ntwk_dp (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ntwk_pkg::ntwk_cmd_type        cmd,
   output      ntwk_pkg::ntwk_stat_type       stat,
   input  wire logic [ntwk_pkg::VALUE_W-1:0] req_value,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic [ntwk_pkg::KEY_W-1:0]   rsp_word_key,
   output      logic                         rsp_last
);
   import ntwk_pkg::*;

   localparam int PH_SCALE = 0;
   localparam int PH_UNITS = 1;
   localparam int PH_TENS  = 2;
   localparam int PH_HUND  = 3;
   localparam int PH_HIGH  = 4;
   localparam int NPH      = 5;

   logic [VALUE_W-1:0] value_ff, value_in, val_step;
   logic [BCD_W-1:0]   bcd_ff, bcd_in, bcd_step;
   logic [GRP_W-1:0]   grp_ff, grp_in;
   logic [NPH-1:0]     pend_ff, pend_in;
   logic               zero_ff, zero_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic               last_ff, last_in;

   logic [NUM_GROUPS-1:0] gnz;
   logic [NPH-1:0]        gmask [NUM_GROUPS];
   logic [GRP_W-1:0]      hi_grp, lo_grp;
   logic                  lower_any;
   logic [NPH-1:0]        hi_mask, lo_mask, sel, pend_left;
   logic [3:0]            d2, d1, d0;
   logic [KEY_W-1:0]      scale, key_sel;
   logic [6:0]            tens_val;

   always_comb begin
      logic [BCD_W-1:0]   b;
      logic [VALUE_W-1:0] v;
      b = bcd_ff;
      v = value_ff;
      for (int s = 0; s < BITS_PER_STEP; s++) begin
         for (int d = 0; d < NDIG; d++) begin
            if (b[d*4 +: 4] >= 4'd5) b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
         end
         b = {b[BCD_W-2:0], v[VALUE_W-1]};
         v = {v[VALUE_W-2:0], 1'b0};
      end
      bcd_step = b;
      val_step = v;
   end

   always_comb begin
      logic [3:0] h, t, u;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         h = bcd_ff[g*GRP_BITS + 8 +: 4];
         t = bcd_ff[g*GRP_BITS + 4 +: 4];
         u = bcd_ff[g*GRP_BITS +: 4];
         gnz[g] = |bcd_ff[g*GRP_BITS +: GRP_BITS];
         gmask[g][PH_HIGH]  = (h != 4'd0);
         gmask[g][PH_HUND]  = (h != 4'd0);
         gmask[g][PH_TENS]  = (t >= 4'd2);
         gmask[g][PH_UNITS] = (t >= 4'd2) ? (u != 4'd0) : ((t != 4'd0) || (u != 4'd0));
         gmask[g][PH_SCALE] = (g != 0);
      end
   end

   always_comb begin
      hi_grp    = '0;
      lo_grp    = '0;
      lower_any = 1'b0;
      hi_mask   = '0;
      lo_mask   = '0;
      d2        = '0;
      d1        = '0;
      d0        = '0;
      scale     = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         if (gnz[g]) begin
            hi_grp  = GRP_W'(g);
            hi_mask = gmask[g];
         end
         if (gnz[g] && (GRP_W'(g) < grp_ff)) begin
            lo_grp    = GRP_W'(g);
            lo_mask   = gmask[g];
            lower_any = 1'b1;
         end
         if (grp_ff == GRP_W'(g)) begin
            d2    = bcd_ff[g*GRP_BITS + 8 +: 4];
            d1    = bcd_ff[g*GRP_BITS + 4 +: 4];
            d0    = bcd_ff[g*GRP_BITS +: 4];
            scale = SCALE_KEY[g];
         end
      end
   end

   always_comb begin
      sel = '0;
      for (int p = 0; p < NPH; p++) begin
         if (pend_ff[p]) sel = NPH'(1) << p;
      end
      pend_left = pend_ff & ~sel;
      tens_val  = 7'({3'b000, d1} * 7'd10);
      key_sel   = '0;
      if (sel[PH_HIGH])  key_sel = KEY_W'(d2);
      if (sel[PH_HUND])  key_sel = KEY_W'(100);
      if (sel[PH_TENS])  key_sel = KEY_W'(tens_val);
      if (sel[PH_UNITS]) key_sel = (d1 >= 4'd2) ? KEY_W'(d0) : KEY_W'(tens_val + 7'(d0));
      if (sel[PH_SCALE]) key_sel = scale;
   end

   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign stat.key_last = zero_ff || ((pend_left == '0) && !lower_any);

   always_comb begin
      value_in     = value_ff;
      bcd_in       = bcd_ff;
      grp_in       = grp_ff;
      pend_in      = pend_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff;
      key_in       = key_ff;
      last_in      = last_ff;
      if (cmd.load) begin
         value_in = req_value;
         bcd_in   = '0;
      end
      if (cmd.step) begin
         value_in = val_step;
         bcd_in   = bcd_step;
      end
      if (cmd.first) begin
         zero_in = (gnz == '0);
         grp_in  = hi_grp;
         pend_in = hi_mask;
      end
      if (cmd.emit) begin
         if ((pend_left == '0) && lower_any) begin
            grp_in  = lo_grp;
            pend_in = lo_mask;
         end else begin
            pend_in = pend_left;
         end
         rsp_valid_in = 1'b1;
         key_in       = zero_ff ? '0 : key_sel;
         last_in      = stat.key_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff <= value_in;
      bcd_ff   <= bcd_in;
      grp_ff   <= grp_in;
      pend_ff  <= pend_in;
      zero_ff  <= zero_in;
      key_ff   <= key_in;
      last_ff  <= last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word_key = key_ff;
   assign rsp_last     = last_ff;

`ifndef NO_ASSERTIONS
   a_pend_live: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (zero_ff || (pend_ff != '0)))
      else $error("key issued with nothing pending");
   a_first_on_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.first |=> (zero_ff || gnz[grp_ff]))
      else $error("group pointer on a zero group");
   a_zero_single: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && zero_ff) |=> (rsp_last && (rsp_word_key == '0)))
      else $error("zero input not a single last key");
`endif

endmodule
`default_nettype wire

@@ hdl/number_to_word_keys_top.sv @@
// Top level: spells an unsigned 64-bit number as a sequence of English word keys.
// Each number yields 1 to 31 keys; a new number is accepted only after the last key is issued.
// Steps: a 16-step decimal conversion (4 bits a cycle), a group setup state, then key emission
// at one key a cycle while the output register is free (not stalled by rsp_ready).
// Reset: synchronous, active high; returns to idle with no result pending.
`default_nettype none
module number_to_word_keys_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic [ntwk_pkg::VALUE_W-1:0] req_value,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic [ntwk_pkg::KEY_W-1:0]   rsp_word_key,
   output      logic                         rsp_last
);
   import ntwk_pkg::*;

   ntwk_cmd_type  cmd;
   ntwk_stat_type stat;

   ntwk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ntwk_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_word_key (rsp_word_key),
      .rsp_last     (rsp_last)
   );

endmodule
`default_nettype wire

@@ tb/tb_number_to_word_keys_top.sv @@
// Self-checking testbench for number_to_word_keys_top: queue-fed driver, key monitor, predictor.
`default_nettype none
module tb_number_to_word_keys_top;
   import ntwk_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int MAX_KEYS     = 34;
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 80;

   typedef struct {
      logic [KEY_W-1:0] key;
      logic             last;
   } word_beat_type;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [VALUE_W-1:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [KEY_W-1:0]   rsp_word_key;
   logic               rsp_last;

   logic [VALUE_W-1:0] numbers_q[$];
   word_beat_type      word_keys_q[$];
   word_beat_type      want_beat;
   logic               req_taken    = 1'b0;
   logic               hold_rsp     = 1'b0;
   logic               squeeze_req  = 1'b0;
   logic               squeeze_done = 1'b0;
   int                 hold_cnt      = 0;
   int                 send_idle_pct = 0;
   int                 stall_pct     = 0;
   int                 errors        = 0;
   int                 numbers_sent  = 0;
   int                 keys_seen     = 0;
   int                 cycles        = 0;

   always #2 clock = ~clock;

   number_to_word_keys_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_word_key (rsp_word_key),
      .rsp_last     (rsp_last)
   );

   // base-1000 split, then keys from the top group down
   function automatic void spell_number(input logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] rest;
      int unsigned        grp [MAX_GROUPS];
      int unsigned        r;
      logic [KEY_W-1:0]   scale;
      logic [KEY_W-1:0]   keys [$];
      int                 n;
      rest = value;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp[g] = 32'(rest % 1000);
         rest   = rest / 1000;
      end
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (grp[g] != 0) begin
            r = grp[g] % 100;
            if (grp[g] > 99) begin
               keys.push_back(KEY_W'((grp[g] / 100) % 10));
               keys.push_back(KEY_W'(100));
            end
            if (r > 19) begin
               keys.push_back(KEY_W'((r / 10) * 10));
               r = r % 10;
            end
            if (r != 0) keys.push_back(KEY_W'(r));
            if (g != 0) begin
               scale = KEY_W'(1);
               for (int s = 0; s < g; s++) scale = scale * KEY_W'(1000);
               keys.push_back(scale);
            end
         end
      end
      if (keys.size() == 0) keys.push_back('0);
      n = (keys.size() > MAX_KEYS) ? MAX_KEYS : keys.size();
      for (int i = 0; i < n; i++) word_keys_q.push_back('{key: keys[i], last: (i == n - 1)});
   endfunction

   function automatic int unsigned pick_group();
      case ($urandom_range(4))
         0: return 0;
         1: return $urandom_range(1, 19);
         2: return $urandom_range(20, 99);
         3: return $urandom_range(100, 999);
         default: return 100 * $urandom_range(1, 9) + $urandom_range(19);
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] random_number();
      logic [VALUE_W-1:0] v;
      int                 ngrp;
      int unsigned        kind;
      kind = $urandom_range(9);
      if (kind < 2) return {$urandom, $urandom};
      if (kind == 2) return VALUE_W'($urandom_range(999));
      v    = '0;
      ngrp = $urandom_range(1, NUM_GROUPS);
      for (int g = ngrp - 1; g >= 0; g--) begin
         if (g == MAX_GROUPS - 1) v = VALUE_W'($urandom_range(18));
         else v = v * VALUE_W'(1000) + VALUE_W'(pick_group());
      end
      return v;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      if (errors <= 100)
         $display("mismatch cycle %0d: %s got %0d want %0d", cycles, what, got, want);
   endtask

   task automatic wait_drained();
      while (numbers_q.size() != 0 || req_valid || word_keys_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(input int idle_pct, input int stall, input int count,
                            input bit squeeze);
      @(posedge clock);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      for (int i = 0; i < count; i++) numbers_q.push_back(random_number());
      if (squeeze) begin
         // output held off while the sender keeps offering
         squeeze_req = 1'b1;
         wait (squeeze_done);
      end
      wait_drained();
   endtask

   // long receiver hold, counted here
   always @(posedge clock) begin
      if (squeeze_req && !squeeze_done) begin
         if (hold_cnt == HOLD_CYCLES) begin
            hold_rsp     <= 1'b0;
            squeeze_done <= 1'b1;
         end else begin
            hold_rsp <= 1'b1;
            hold_cnt <= hold_cnt + 1;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (numbers_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_value <= numbers_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset || hold_rsp) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            spell_number(req_value);
            numbers_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            keys_seen++;
            if (word_keys_q.size() == 0) begin
               report_mismatch("unexpected beat, word_key", 64'(rsp_word_key), 64'(0));
            end else begin
               want_beat = word_keys_q.pop_front();
               if (rsp_word_key !== want_beat.key)
                  report_mismatch("word_key", 64'(rsp_word_key), 64'(want_beat.key));
               if (rsp_last !== want_beat.last)
                  report_mismatch("last", 64'(rsp_last), 64'(want_beat.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d keys outstanding", cycles, word_keys_q.size());
         $display("tb_number_to_word_keys_top failed");
         $finish;
      end
   end

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      numbers_q.push_back(64'd0);
      numbers_q.push_back(64'd1);
      numbers_q.push_back(64'd9);
      numbers_q.push_back(64'd10);
      numbers_q.push_back(64'd11);
      numbers_q.push_back(64'd19);
      numbers_q.push_back(64'd20);
      numbers_q.push_back(64'd21);
      numbers_q.push_back(64'd99);
      numbers_q.push_back(64'd100);
      numbers_q.push_back(64'd101);
      numbers_q.push_back(64'd110);
      numbers_q.push_back(64'd119);
      numbers_q.push_back(64'd120);
      numbers_q.push_back(64'd999);
      numbers_q.push_back(64'd1000);
      numbers_q.push_back(64'd1001);
      numbers_q.push_back(64'd1000000);
      numbers_q.push_back(64'd1000000000000);
      numbers_q.push_back(64'd1000000000000000000);
      numbers_q.push_back(64'd10000000000000000000);
      numbers_q.push_back(64'd18000000000000000000);
      numbers_q.push_back(64'd17777777777777777777);
      numbers_q.push_back(64'h8000_0000_0000_0000);
      numbers_q.push_back({VALUE_W{1'b1}});
      wait_drained();
      run_phase(0, 0, 100, 1'b1);
      run_phase(68, 0, 100, 1'b0);
      run_phase(0, 68, 100, 1'b0);
      run_phase(35, 35, 100, 1'b0);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d numbers: edge values, 1 to 7 group mixes, full 64-bit; %0d keys",
               numbers_sent, keys_seen);
      $display("pacing: free run, sender gaps, receiver stalls, both, and a long output hold");
      if (errors == 0 && word_keys_q.size() == 0) begin
         $display("tb_number_to_word_keys_top passed");
      end else begin
         $display("%0d mismatches, %0d keys never seen", errors, word_keys_q.size());
         $display("tb_number_to_word_keys_top failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
